// File: hw/rtl/i64da_pkg.sv
// ----------------------------------------------------------------------------
// i64da_pkg
// Shared types, constants and the binary-to-BCD step for the int64 printer.
// ----------------------------------------------------------------------------
package i64da_pkg;

    localparam int VALUE_W       = 64;
    localparam int NUM_DIGITS    = 19;               // |value| <= 2^63 has 19 digits
    localparam int BCD_W         = NUM_DIGITS * 4;
    localparam int STEPS_PER_STG = 4;                // shift-add-3 steps per stage
    localparam int NUM_STAGES    = VALUE_W / STEPS_PER_STG;
    localparam int POS_W         = 5;                // holds digit index 0..18

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [3:0] ADJ_LIMIT  = 4'd5;
    localparam logic [3:0] ADJ_ADD    = 4'd3;

    // Converted number handed to the serializer
    typedef struct packed {
        logic              valid;
        logic              neg;
        logic [POS_W-1:0]  top;      // index of the most significant digit
        logic [BCD_W-1:0]  bcd;
    } conv_out_t;

    // One double-dabble step over {bcd, bin}
    function automatic logic [BCD_W+VALUE_W-1:0] dabble_step(
        input logic [BCD_W+VALUE_W-1:0] w
    );
        logic [BCD_W+VALUE_W-1:0] r;
        logic [3:0]               dg;
        r = w;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            dg = r[VALUE_W + 4*d +: 4];
            if (dg >= ADJ_LIMIT) begin
                r[VALUE_W + 4*d +: 4] = dg + ADJ_ADD;
            end
        end
        return {r[BCD_W+VALUE_W-2:0], 1'b0};
    endfunction

endpackage

// File: hw/rtl/i64da_conv.sv
// ----------------------------------------------------------------------------
// i64da_conv
// Pipelined magnitude and binary-to-BCD conversion, four bits per stage.
// ----------------------------------------------------------------------------
module i64da_conv
    import i64da_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,        // whole pipe moves one stage
    input  logic               in_valid,
    input  logic [VALUE_W-1:0] in_value,
    output conv_out_t          out
);

    logic [NUM_STAGES:0]  vld_reg;
    logic [NUM_STAGES:0]  neg_reg;
    logic [VALUE_W-1:0]   bin_reg [NUM_STAGES+1];
    logic [BCD_W-1:0]     bcd_reg [NUM_STAGES+1];
    conv_out_t            out_reg;
    conv_out_t            out_next;

    // Stage 0: sign and magnitude
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
        end
        if (adv) begin
            neg_reg[0] <= in_value[VALUE_W-1];
            bin_reg[0] <= in_value[VALUE_W-1] ? (~in_value + 64'd1) : in_value;
            bcd_reg[0] <= '0;
        end
    end

    // Dabble stages
    for (genvar s = 1; s <= NUM_STAGES; s++) begin : g_stg
        logic [BCD_W+VALUE_W-1:0] w [STEPS_PER_STG+1];
        always_comb begin
            w[0] = {bcd_reg[s-1], bin_reg[s-1]};
            for (int k = 0; k < STEPS_PER_STG; k++) begin
                w[k+1] = dabble_step(w[k]);
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (adv) begin
                vld_reg[s] <= vld_reg[s-1];
            end
            if (adv) begin
                neg_reg[s] <= neg_reg[s-1];
                bin_reg[s] <= w[STEPS_PER_STG][VALUE_W-1:0];
                bcd_reg[s] <= w[STEPS_PER_STG][BCD_W+VALUE_W-1:VALUE_W];
            end
        end
    end

    // Final stage: locate the leading nonzero digit
    always_comb begin
        out_next       = '0;
        out_next.valid = vld_reg[NUM_STAGES];
        out_next.neg   = neg_reg[NUM_STAGES];
        out_next.bcd   = bcd_reg[NUM_STAGES];
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_reg[NUM_STAGES][4*d +: 4] != 4'd0) begin
                out_next.top = POS_W'(d);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (adv) begin
            out_reg.valid <= out_next.valid;
        end
        if (adv) begin
            out_reg.neg <= out_next.neg;
            out_reg.top <= out_next.top;
            out_reg.bcd <= out_next.bcd;
        end
    end

    assign out = out_reg;

endmodule

// File: hw/rtl/int64_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii
// Prints a signed 64-bit value as decimal ASCII, one character per request.
// ----------------------------------------------------------------------------
// Each input request carries one two's-complement value; the block answers
// with 1 to 20 output requests, a '-' for negative values then the digits
// most significant first, without leading zeros, tlast on the final one.
// The conversion is an 18-stage pipeline (magnitude, sixteen stages of four
// shift-add-3 steps, leading-digit search) followed by the serializer
// register; the whole pipeline stalls while a converted number waits for the
// busy serializer. The single-byte output port sets the sustained rate: a
// number of N characters takes N output handshakes, and the next number
// follows its final character with no gap when it is already converted.
module int64_to_decimal_ascii
    import i64da_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // [63:0] value
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] text_byte
    output logic               m_tlast    // last_char
);

    conv_out_t          conv;
    logic               adv;
    logic               load;
    logic               busy_reg;
    logic               sign_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [BCD_W-1:0]   dig_reg;
    logic               take;

    // Serializer frees up on the final character handshake
    assign take     = m_tvalid && m_tready;
    assign load     = !busy_reg || (take && m_tlast);
    assign adv      = !conv.valid || load;
    assign s_tready = adv;

    i64da_conv u_conv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_tvalid),
        .in_value (s_tdata),
        .out      (conv)
    );

    // Character serializer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (load) begin
            busy_reg <= conv.valid;
        end
        if (load) begin
            sign_reg <= conv.neg;
            pos_reg  <= conv.top;
            dig_reg  <= conv.bcd;
        end else if (take) begin
            if (sign_reg) begin
                sign_reg <= 1'b0;
            end else begin
                pos_reg <= pos_reg - POS_W'(1);
            end
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = sign_reg ? CHAR_MINUS
                               : (CHAR_ZERO | {4'd0, dig_reg[4*pos_reg +: 4]});
    assign m_tlast  = !sign_reg && (pos_reg == '0);

    // Minus sign is never the final character
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && sign_reg) |-> !m_tlast)
        else $error("minus sign marked last");

    // Digit index stays inside the digit store
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pos_reg < POS_W'(NUM_DIGITS)))
        else $error("digit index out of range");

    // Serializer drains when nothing is queued behind the last character
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && m_tlast && !conv.valid) |=> !m_tvalid)
        else $error("output valid after drain");

endmodule
